// ===== sv/pftv_pkg.sv =====
// ----------------------------------------------------------------------------
// pftv_pkg
// Shared constants, types and helpers of the pose frame transform block.
// ----------------------------------------------------------------------------
package pftv_pkg;

	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int TRIG_W  = 18;
	localparam int PROD_W  = 50;
	localparam int ACC_W   = 51;
	localparam int CHG_W   = 33;
	localparam int NUM_W   = 42;
	localparam int DEN_W   = 32;
	localparam int LANES   = 3;
	localparam int RATE_SCALE = 1000;

	localparam logic [2:0] REG_HEADING_OFFSET = 3'd0;
	localparam logic [2:0] REG_OFFSET_COSINE  = 3'd1;
	localparam logic [2:0] REG_OFFSET_SINE    = 3'd2;
	localparam logic [2:0] REG_X_TRANSLATION  = 3'd3;
	localparam logic [2:0] REG_Y_TRANSLATION  = 3'd4;

	localparam logic signed [TRIG_W-1:0] COSINE_RESET = 18'sd65536;

	typedef struct packed {
		logic signed [31:0]       heading_offset;
		logic signed [TRIG_W-1:0] offset_cosine;
		logic signed [TRIG_W-1:0] offset_sine;
		logic signed [31:0]       x_translation;
		logic signed [31:0]       y_translation;
	} cfg_t;

	typedef struct packed {
		logic       take;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       acc_en;
		logic [1:0] acc_sel;
		logic       pos_en;
		logic       diff_en;
		logic       scale_en;
		logic       div_start;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	// signed saturation of a sign-magnitude quotient
	function automatic logic [31:0] sat_rate(input logic [NUM_W-1:0] q, input logic neg);
		logic big;
		big = |q[NUM_W-1:32];
		if (!neg) begin
			return (big || q[31]) ? 32'h7fff_ffff : q[31:0];
		end
		return (big || (q[31] && |q[30:0])) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
	endfunction

endpackage

// ===== sv/pftv_smp_if.sv =====
// ----------------------------------------------------------------------------
// pftv_smp_if
// Sample channel: raw tracker pose and timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface pftv_smp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] raw_x;
	logic signed [31:0] raw_y;
	logic signed [31:0] raw_heading;
	logic        [31:0] time_ms;

	modport source (output valid, raw_x, raw_y, raw_heading, time_ms, input ready);
	modport sink (input valid, raw_x, raw_y, raw_heading, time_ms, output ready);
endinterface

// ===== sv/pftv_res_if.sv =====
// ----------------------------------------------------------------------------
// pftv_res_if
// Result channel: field-frame pose and rates with valid/ready.
// ----------------------------------------------------------------------------
interface pftv_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_heading;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_heading;

	modport source (output valid, pos_x, pos_y, pos_heading, vel_x, vel_y, vel_heading,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_heading, vel_x, vel_y, vel_heading,
		output ready);
endinterface

// ===== sv/pftv_regs.sv =====
// ----------------------------------------------------------------------------
// pftv_regs
// APB-style configuration registers: offsets, sine and cosine of the offset.
// ----------------------------------------------------------------------------
module pftv_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pftv_pkg::ADDR_W-1:0] paddr,
	input  logic [pftv_pkg::DATA_W-1:0] pwdata,
	output logic [pftv_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output pftv_pkg::cfg_t              cfg
);

	pftv_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heading_offset <= '0;
			cfg_q.offset_cosine  <= pftv_pkg::COSINE_RESET;
			cfg_q.offset_sine    <= '0;
			cfg_q.x_translation  <= '0;
			cfg_q.y_translation  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				pftv_pkg::REG_HEADING_OFFSET: cfg_q.heading_offset <= pwdata;
				pftv_pkg::REG_OFFSET_COSINE:  cfg_q.offset_cosine  <= pwdata[pftv_pkg::TRIG_W-1:0];
				pftv_pkg::REG_OFFSET_SINE:    cfg_q.offset_sine    <= pwdata[pftv_pkg::TRIG_W-1:0];
				pftv_pkg::REG_X_TRANSLATION:  cfg_q.x_translation  <= pwdata;
				pftv_pkg::REG_Y_TRANSLATION:  cfg_q.y_translation  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pftv_pkg::REG_HEADING_OFFSET: prdata = cfg_q.heading_offset;
			pftv_pkg::REG_OFFSET_COSINE:  prdata = {{14{cfg_q.offset_cosine[17]}}, cfg_q.offset_cosine};
			pftv_pkg::REG_OFFSET_SINE:    prdata = {{14{cfg_q.offset_sine[17]}}, cfg_q.offset_sine};
			pftv_pkg::REG_X_TRANSLATION:  prdata = cfg_q.x_translation;
			pftv_pkg::REG_Y_TRANSLATION:  prdata = cfg_q.y_translation;
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== sv/pftv_div.sv =====
// ----------------------------------------------------------------------------
// pftv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pftv_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pftv_pkg::NUM_W-1:0] num,
	input  logic [pftv_pkg::DEN_W-1:0] den,
	output logic [pftv_pkg::NUM_W-1:0] quo,
	output logic                       done
);

	localparam int NW    = pftv_pkg::NUM_W;
	localparam int DW    = pftv_pkg::DEN_W;
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW+1:0]    trial;
	logic [DW:0]      rem_sh;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
	assign quo    = num_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== sv/pftv_ctrl.sv =====
// ----------------------------------------------------------------------------
// pftv_ctrl
// Sequencer: rotation products, pose, differences, division, result load.
// ----------------------------------------------------------------------------
module pftv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output pftv_pkg::cmd_t  cmd,
	input  pftv_pkg::stat_t stat
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_POS   = 8'b0000_0100,
		S_DIFF  = 8'b0000_1000,
		S_SCALE = 8'b0001_0000,
		S_START = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	localparam logic [2:0] MUL_LAST = 3'd4;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en  = (cnt_q != MUL_LAST);
				cmd.mul_sel = cnt_q[1:0];
				cmd.acc_en  = (cnt_q != 3'd0);
				cmd.acc_sel = 2'(cnt_q - 3'd1);
				if (cnt_q == MUL_LAST) begin
					state_d = S_POS;
				end
			end
			S_POS: begin
				cmd.pos_en = 1'b1;
				state_d    = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale_en = 1'b1;
				state_d      = S_START;
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/pftv_dp.sv =====
// ----------------------------------------------------------------------------
// pftv_dp
// Datapath: shared rotation multiplier, offsets, differences, three dividers.
// ----------------------------------------------------------------------------
module pftv_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pftv_pkg::cmd_t      cmd,
	output pftv_pkg::stat_t     stat,
	input  pftv_pkg::cfg_t      cfg,
	input  logic signed [31:0]  raw_x,
	input  logic signed [31:0]  raw_y,
	input  logic signed [31:0]  raw_heading,
	input  logic        [31:0]  time_ms,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_heading,
	output logic signed [31:0]  vel_x,
	output logic signed [31:0]  vel_y,
	output logic signed [31:0]  vel_heading
);

	localparam int L = pftv_pkg::LANES;

	logic signed [31:0]                  rx_q;
	logic signed [31:0]                  ry_q;
	logic signed [31:0]                  rh_q;
	logic        [31:0]                  now_q;
	logic signed [31:0]                  mul_a;
	logic signed [pftv_pkg::TRIG_W-1:0]  mul_b;
	logic signed [pftv_pkg::PROD_W-1:0]  prod_s1;
	logic signed [pftv_pkg::ACC_W-1:0]   prod_ext;
	logic signed [pftv_pkg::ACC_W-1:0]   acc_x_q;
	logic signed [pftv_pkg::ACC_W-1:0]   acc_y_q;
	logic        [47:0]                  sum_x;
	logic        [47:0]                  sum_y;
	logic        [31:0]                  dt_q;
	logic                                dt_zero;
	logic        [31:0]                  pos_q   [L];
	logic        [31:0]                  last_q  [L];
	logic        [31:0]                  speed_q [L];
	logic        [31:0]                  last_time_q;
	logic        [pftv_pkg::CHG_W-1:0]   chg_q   [L];
	logic        [pftv_pkg::NUM_W-1:0]   mag_q   [L];
	logic                                neg_q   [L];
	logic        [pftv_pkg::NUM_W-1:0]   quo     [L];
	logic        [L-1:0]                 done;

	// rotation operands: rx*cos, ry*sin, rx*sin, ry*cos
	assign mul_a    = cmd.mul_sel[0] ? ry_q : rx_q;
	assign mul_b    = (cmd.mul_sel[0] ^ cmd.mul_sel[1]) ? cfg.offset_sine : cfg.offset_cosine;
	assign prod_ext = {prod_s1[pftv_pkg::PROD_W-1], prod_s1};

	// round half up and translate in one add, kept modulo 2^48
	assign sum_x = acc_x_q[47:0] + 48'h0000_0000_8000 + {cfg.x_translation, 16'h0000};
	assign sum_y = acc_y_q[47:0] + 48'h0000_0000_8000 + {cfg.y_translation, 16'h0000};
	assign dt_zero = (dt_q == 32'd0);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rx_q  <= raw_x;
			ry_q  <= raw_y;
			rh_q  <= raw_heading;
			now_q <= time_ms;
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (cmd.acc_en) begin
			unique case (cmd.acc_sel)
				2'd0: acc_x_q <= prod_ext;
				2'd1: acc_x_q <= acc_x_q - prod_ext;
				2'd2: acc_y_q <= prod_ext;
				2'd3: acc_y_q <= acc_y_q + prod_ext;
				default: ;
			endcase
		end
		if (cmd.pos_en) begin
			pos_q[0] <= sum_x[47:16];
			pos_q[1] <= sum_y[47:16];
			pos_q[2] <= rh_q + cfg.heading_offset;
			dt_q     <= now_q - last_time_q;
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_lane
		logic [pftv_pkg::CHG_W-1:0] abs_chg;

		assign abs_chg = chg_q[i][pftv_pkg::CHG_W-1] ? (~chg_q[i] + 1'b1) : chg_q[i];

		always_ff @(posedge clk) begin
			if (cmd.diff_en) begin
				chg_q[i] <= {pos_q[i][31], pos_q[i]} - {last_q[i][31], last_q[i]};
			end
			if (cmd.scale_en) begin
				neg_q[i] <= chg_q[i][pftv_pkg::CHG_W-1];
				mag_q[i] <= pftv_pkg::NUM_W'(abs_chg) * pftv_pkg::NUM_W'(pftv_pkg::RATE_SCALE);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_q[i]  <= '0;
				speed_q[i] <= '0;
			end else if (cmd.out_load) begin
				last_q[i] <= pos_q[i];
				if (!dt_zero) begin
					speed_q[i] <= pftv_pkg::sat_rate(quo[i], neg_q[i]);
				end
			end
		end

		pftv_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.div_start),
			.num    (mag_q[i]),
			.den    (dt_q),
			.quo    (quo[i]),
			.done   (done[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (cmd.out_load) begin
			last_time_q <= now_q;
		end
	end

	assign stat.div_done = &done;

	assign pos_x       = last_q[0];
	assign pos_y       = last_q[1];
	assign pos_heading = last_q[2];
	assign vel_x       = speed_q[0];
	assign vel_y       = speed_q[1];
	assign vel_heading = speed_q[2];

endmodule

// ===== sv/pose_frame_transform_velocity.sv =====
// ----------------------------------------------------------------------------
// pose_frame_transform_velocity
// Tracker pose to field frame with finite-difference velocity.
// ----------------------------------------------------------------------------
// One sample is processed at a time. From acceptance, the rotation products
// are formed on the shared 32x18 rotation multiplier; then come the offsets,
// differences and the x1000 scaling; then the three restoring dividers that
// run side by side are started, give 42 quotient bits at one bit per cycle
// and are seen to finish; and then the result is loaded.
// The next sample can be taken in the cycle after the load. The result sits
// in an output register, so the next sample is taken while it waits; a sample
// whose result is still pending holds the block in its last step until the
// output register frees.
// ----------------------------------------------------------------------------
module pose_frame_transform_velocity (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pftv_pkg::ADDR_W-1:0] paddr,
	input  logic [pftv_pkg::DATA_W-1:0] pwdata,
	output logic [pftv_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	pftv_smp_if.sink                    sample,
	pftv_res_if.source                  result
);

	pftv_pkg::cfg_t  cfg;
	pftv_pkg::cmd_t  cmd;
	pftv_pkg::stat_t stat;

	pftv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pftv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pftv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg),
		.raw_x       (sample.raw_x),
		.raw_y       (sample.raw_y),
		.raw_heading (sample.raw_heading),
		.time_ms     (sample.time_ms),
		.pos_x       (result.pos_x),
		.pos_y       (result.pos_y),
		.pos_heading (result.pos_heading),
		.vel_x       (result.vel_x),
		.vel_y       (result.vel_y),
		.vel_heading (result.vel_heading)
	);

endmodule

// ===== sv/pftv_checker.sv =====
// ----------------------------------------------------------------------------
// pftv_checker
// Port-level checks of the pose transform block, bound to the top level.
// ----------------------------------------------------------------------------
module pftv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        smp_valid,
	input logic                        smp_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [31:0]                 res_pos_heading,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [pftv_pkg::ADDR_W-1:0] paddr,
	input logic [pftv_pkg::DATA_W-1:0] pwdata,
	input logic [pftv_pkg::DATA_W-1:0] prdata
);

	// stalled word stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_pos_heading))
		else $error("result word changed while stalled");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready ##1 !smp_ready)
		else $error("sample taken while another is in work");

	// heading offset reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == {pftv_pkg::REG_HEADING_OFFSET, 2'b00}) |=>
		(paddr != {pftv_pkg::REG_HEADING_OFFSET, 2'b00}) || (prdata == $past(pwdata)))
		else $error("heading offset readback mismatch");

endmodule

bind pose_frame_transform_velocity pftv_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.smp_valid       (sample.valid),
	.smp_ready       (sample.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_pos_heading (result.pos_heading),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr),
	.pwdata          (pwdata),
	.prdata          (prdata)
);

// ===== sim/pose_frame_transform_velocity_tb.sv =====
// ----------------------------------------------------------------------------
// pose_frame_transform_velocity_tb
// Self-checking bench for the tracker pose transform and rate block. Samples
// go in through the sample channel, and a local tracker model predicts the
// field-frame pose and rates for each accepted word. Results are checked in
// order. Offsets are set over APB between phases, reset values and extremes
// included, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pose_frame_transform_velocity_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		logic signed [31:0] raw_x;
		logic signed [31:0] raw_y;
		logic signed [31:0] raw_heading;
		logic        [31:0] time_ms;
	} tracker_sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_heading;
	} field_pose_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [pftv_pkg::ADDR_W-1:0] paddr;
	logic [pftv_pkg::DATA_W-1:0] pwdata;
	logic [pftv_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	pftv_smp_if smp ();
	pftv_res_if res ();

	pose_frame_transform_velocity dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (smp),
		.result  (res)
	);

	// offset registers as the block should hold them
	logic signed [31:0]                 hdg_offset;
	logic signed [pftv_pkg::TRIG_W-1:0] cos_q;
	logic signed [pftv_pkg::TRIG_W-1:0] sin_q;
	logic signed [31:0]                 x_trans;
	logic signed [31:0]                 y_trans;

	// tracker history
	logic signed [31:0] prev_x;
	logic signed [31:0] prev_y;
	logic signed [31:0] prev_heading;
	logic        [31:0] prev_time;
	logic signed [31:0] spd_x;
	logic signed [31:0] spd_y;
	logic signed [31:0] spd_heading;

	// random walk of the simulated robot
	logic [31:0] walk_x;
	logic [31:0] walk_y;
	logic [31:0] walk_heading;
	logic [31:0] walk_time;

	field_pose_t expected_poses[$];
	int          failures;
	int          cycle_count;
	int          send_idle_pct;
	int          stall_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pose_frame_transform_velocity verification failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] rate_of(input longint change, input logic [31:0] dt,
			input logic signed [31:0] held);
		longint q;
		if (dt == 32'd0)
			return held;
		q = (change * 1000) / longint'({32'd0, dt});
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic field_pose_t advance_tracker(input tracker_sample_t s);
		logic signed [63:0] acc_x;
		logic signed [63:0] acc_y;
		logic signed [63:0] rnd_x;
		logic signed [63:0] rnd_y;
		logic        [31:0] dt;
		field_pose_t        p;
		acc_x = longint'(s.raw_x) * longint'(cos_q) - longint'(s.raw_y) * longint'(sin_q);
		acc_y = longint'(s.raw_x) * longint'(sin_q) + longint'(s.raw_y) * longint'(cos_q);
		// round half up to Q16.16
		rnd_x = (acc_x + 64'sd32768) >>> 16;
		rnd_y = (acc_y + 64'sd32768) >>> 16;
		p.pos_x = rnd_x[31:0] + x_trans;
		p.pos_y = rnd_y[31:0] + y_trans;
		p.pos_heading = s.raw_heading + hdg_offset;
		dt = s.time_ms - prev_time;
		spd_x = rate_of(longint'(p.pos_x) - longint'(prev_x), dt, spd_x);
		spd_y = rate_of(longint'(p.pos_y) - longint'(prev_y), dt, spd_y);
		spd_heading = rate_of(longint'(p.pos_heading) - longint'(prev_heading), dt, spd_heading);
		p.vel_x = spd_x;
		p.vel_y = spd_y;
		p.vel_heading = spd_heading;
		prev_x = p.pos_x;
		prev_y = p.pos_y;
		prev_heading = p.pos_heading;
		prev_time = s.time_ms;
		return p;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			failures++;
		end
	endfunction

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		field_pose_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_poses.size() == 0) begin
				$error("result word with no sample pending");
				failures++;
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", want.pos_x, res.pos_x);
				check_field("pos_y", want.pos_y, res.pos_y);
				check_field("pos_heading", want.pos_heading, res.pos_heading);
				check_field("vel_x", want.vel_x, res.vel_x);
				check_field("vel_y", want.vel_y, res.vel_y);
				check_field("vel_heading", want.vel_heading, res.vel_heading);
			end
		end
	end

	task automatic send_sample(input tracker_sample_t s);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			smp.valid = 1'b0;
			@(negedge clk);
		end
		smp.valid = 1'b1;
		smp.raw_x = s.raw_x;
		smp.raw_y = s.raw_y;
		smp.raw_heading = s.raw_heading;
		smp.time_ms = s.time_ms;
		do @(posedge clk); while (!smp.ready);
		expected_poses.push_back(advance_tracker(s));
		@(negedge clk);
	endtask

	task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic [31:0] h,
			input logic [31:0] t);
		send_sample('{raw_x: x, raw_y: y, raw_heading: h, time_ms: t});
	endtask

	task automatic wait_results_done();
		smp.valid = 1'b0;
		while (expected_poses.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			pftv_pkg::REG_HEADING_OFFSET: hdg_offset = value;
			pftv_pkg::REG_OFFSET_COSINE:  cos_q = value[pftv_pkg::TRIG_W-1:0];
			pftv_pkg::REG_OFFSET_SINE:    sin_q = value[pftv_pkg::TRIG_W-1:0];
			pftv_pkg::REG_X_TRANSLATION:  x_trans = value;
			pftv_pkg::REG_Y_TRANSLATION:  y_trans = value;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_offsets(input logic [31:0] h, input logic [31:0] c, input logic [31:0] s,
			input logic [31:0] xt, input logic [31:0] yt);
		wait_results_done();
		write_reg(pftv_pkg::REG_HEADING_OFFSET, h);
		write_reg(pftv_pkg::REG_OFFSET_COSINE, c);
		write_reg(pftv_pkg::REG_OFFSET_SINE, s);
		write_reg(pftv_pkg::REG_X_TRANSLATION, xt);
		write_reg(pftv_pkg::REG_Y_TRANSLATION, yt);
	endtask

	function automatic tracker_sample_t next_walk_sample();
		int          pick;
		logic [31:0] span;
		pick = $urandom_range(99);
		if (pick < 10) begin
			walk_x = $urandom;
			walk_y = $urandom;
			walk_heading = $urandom;
			walk_time = $urandom;
		end else begin
			if (pick < 15)
				walk_time = walk_time;
			else if (pick < 18)
				walk_time = walk_time + $urandom;
			else
				walk_time = walk_time + $urandom_range(1, 40);
			span = (pick < 30) ? 32'h7fff_ffff : 32'h0004_0000;
			walk_x = walk_x + $urandom_range(0, span) - (span >> 1);
			walk_y = walk_y + $urandom_range(0, span) - (span >> 1);
			walk_heading = walk_heading + $urandom_range(0, span >> 2) - (span >> 3);
		end
		return '{raw_x: walk_x, raw_y: walk_y, raw_heading: walk_heading, time_ms: walk_time};
	endfunction

	task automatic test_first_sample();
		// differenced against the zero pose at time zero
		send_pose(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'd10);
		send_pose(32'h0001_8000, 32'hfffe_0000, 32'hffff_0000, 32'd35);
	endtask

	task automatic test_zero_dt();
		send_pose(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'd35);
		send_pose(32'h0006_0000, 32'h0004_0000, 32'h0002_0000, 32'd35);
		send_pose(32'h0007_0000, 32'h0004_0000, 32'h0002_0000, 32'd36);
	endtask

	task automatic test_time_wrap();
		send_pose(32'h0008_0000, 32'h0001_0000, 32'h0000_0000, 32'hffff_fff0);
		send_pose(32'h0009_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0010);
		send_pose(32'h0009_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_000f);
	endtask

	task automatic test_field_extremes();
		send_pose(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100);
		send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0101);
		send_pose(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0102);
		send_pose(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
		send_pose(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff);
	endtask

	task automatic test_offset_extremes();
		set_offsets(32'h7fff_ffff, 32'hfffe_0000, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_pose(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0004);
		// sine and cosine patterns outside the unit range
		set_offsets(32'h8000_0000, 32'h0001_ffff, 32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0005);
		send_pose(32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 32'h8000_0006);
		set_offsets(32'h0000_0000, 32'h0003_ffff, 32'h0001_ffff, 32'h0000_0000, 32'h0000_0000);
		send_pose(32'h0001_2345, 32'hfedc_ba98, 32'h0000_c000, 32'h8000_0010);
		send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h8000_0011);
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int count,
			input bit pressure);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			if (pressure && n % 50 == 25)
				wait_results_done();
			send_sample(next_walk_sample());
		end
		wait_results_done();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic randomize_offsets();
		logic [31:0] c;
		logic [31:0] s;
		if ($urandom_range(1) == 1) begin
			c = 32'($urandom_range(0, 131072)) - 32'd65536;
			s = 32'($urandom_range(0, 131072)) - 32'd65536;
		end else begin
			c = $urandom;
			s = $urandom;
		end
		set_offsets($urandom, c, s, $urandom, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.raw_x = '0;
		smp.raw_y = '0;
		smp.raw_heading = '0;
		smp.time_ms = '0;
		res.ready = 1'b0;
		failures = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hdg_offset = '0;
		cos_q = pftv_pkg::COSINE_RESET;
		sin_q = '0;
		x_trans = '0;
		y_trans = '0;
		prev_x = '0;
		prev_y = '0;
		prev_heading = '0;
		prev_time = '0;
		spd_x = '0;
		spd_y = '0;
		spd_heading = '0;
		walk_x = '0;
		walk_y = '0;
		walk_heading = '0;
		walk_time = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_sample();
		test_zero_dt();
		test_time_wrap();
		test_field_extremes();
		test_offset_extremes();

		set_offsets(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		test_random_phase(0, 0, 200, 1'b0);
		randomize_offsets();
		test_random_phase(88, 0, 200, 1'b1);
		set_offsets(32'h0003_243f, 32'hffff_0000, 32'h0000_0000, 32'h0010_0000, 32'hfff0_0000);
		test_random_phase(0, 88, 200, 1'b0);
		randomize_offsets();
		test_random_phase(29, 29, 200, 1'b1);
		set_offsets(32'hfffe_6de1, 32'h0000_0000, 32'hffff_0000, 32'h8000_0000, 32'h7fff_ffff);
		test_random_phase(0, 0, 100, 1'b0);

		wait_results_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && expected_poses.size() == 0)
			$display("pose_frame_transform_velocity verification clean");
		else
			$display("pose_frame_transform_velocity verification failed");
		$finish;
	end

endmodule
